/* src/dcfp_pkg.sv */
// shared types, command codes, reset values and the brightness table
// for the display command frame parser; no dependencies
package dcfp_pkg;

  localparam int DIGIT_COUNT_DEF = 4;
  localparam int LEVEL_STEPS_DEF = 12;

  // bus bytes
  localparam logic [7:0] ADDR_BROADCAST  = 8'hFF;
  localparam logic [7:0] CMD_SET_LEVEL   = 8'hA0;
  localparam logic [7:0] CMD_LEVEL_DOWN  = 8'hA1;
  localparam logic [7:0] CMD_LEVEL_UP    = 8'hA2;
  localparam logic [7:0] CMD_LOAD_DIGITS = 8'hAB;
  localparam logic [7:0] CMD_SAVE        = 8'hAC;
  localparam logic [7:0] CMD_SHOW_INDIC  = 8'h96;
  localparam logic [7:0] CMD_SHOW_MODE   = 8'h98;
  localparam logic [7:0] CMD_SHOW_ADDR   = 8'h99;
  localparam logic [7:0] CMD_RESET       = 8'hFE;
  localparam logic [7:0] RESET_OPERAND   = 8'h01;

  // ascii translation of digit bytes
  localparam logic [7:0] CHAR_LOW   = 8'h2A;
  localparam logic [7:0] CHAR_HIGH  = 8'h3F;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [5:0] CODE_MINUS = 6'd10;
  localparam logic [5:0] CODE_OTHER = 6'd11;

  // show request codes
  localparam logic [1:0] SHOW_NONE  = 2'd0;
  localparam logic [1:0] SHOW_INDIC = 2'd1;
  localparam logic [1:0] SHOW_MODE  = 2'd2;
  localparam logic [1:0] SHOW_ADDR  = 2'd3;

  // configuration register indexes
  localparam logic REG_BOARD_ADDRESS  = 1'b0;
  localparam logic REG_MAX_DIGIT_CODE = 1'b1;

  // reset values
  localparam logic [7:0] BOARD_ADDRESS_RST  = 8'd101;
  localparam logic [5:0] MAX_DIGIT_CODE_RST = 6'd12;
  localparam logic [3:0] STEP_RST           = 4'd10;
  localparam logic [7:0] LEVEL_RST          = 8'd214;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_CMD    = 3'd1,
    PH_LEVEL  = 3'd2,
    PH_DIGITS = 3'd3,
    PH_SKIP   = 3'd4,
    PH_RESET  = 3'd5
  } phase_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] pwm_level;
    logic [3:0] level_step;
    logic [5:0] digit_zero;
    logic [5:0] digit_one;
    logic [5:0] digit_two;
    logic [5:0] digit_three;
    logic       refresh;
    logic       save_digits;
    logic       soft_reset;
    logic [1:0] show_request;
    logic       frame_dropped;
  } result_t;

  typedef struct packed {
    logic [7:0] board_address;
    logic [5:0] max_digit_code;
  } cfg_t;

  // brightness compare value per step; steps past the table read full scale
  function automatic logic [7:0] level_at(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'd5;
      4'd1:    v = 8'd30;
      4'd2:    v = 8'd40;
      4'd3:    v = 8'd50;
      4'd4:    v = 8'd62;
      4'd5:    v = 8'd77;
      4'd6:    v = 8'd95;
      4'd7:    v = 8'd118;
      4'd8:    v = 8'd146;
      4'd9:    v = 8'd181;
      4'd10:   v = 8'd214;
      4'd11:   v = 8'd250;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

  // power-up digit code of a slot: 1,2,3,4 then blank zero
  function automatic logic [5:0] digit_reset(input int unsigned k);
    logic [5:0] v;
    v = (k < 4) ? 6'(k + 1) : 6'd0;
    return v;
  endfunction

endpackage

/* src/dcfp_digit_fix.sv */
// translation of one received digit byte into a display code
// depends on dcfp_pkg
module dcfp_digit_fix import dcfp_pkg::*; (
  input  logic [7:0] rx_byte,
  input  logic [5:0] old_code,
  input  logic [5:0] max_digit_code,
  output logic [5:0] code
);

  always_comb begin
    if (rx_byte <= {2'b00, max_digit_code}) begin
      code = rx_byte[5:0];
    end else if (rx_byte inside {[CHAR_LOW:CHAR_HIGH]}) begin
      if (rx_byte == CHAR_MINUS) begin
        code = CODE_MINUS;
      end else if (rx_byte inside {[CHAR_ZERO:CHAR_NINE]}) begin
        code = {2'b00, rx_byte[3:0]};
      end else begin
        code = CODE_OTHER;
      end
    end else begin
      code = old_code;
    end
  end

endmodule

/* src/dcfp_level_search.sv */
// brightness step lookup: first table step whose value is not below the level
// depends on dcfp_pkg
module dcfp_level_search import dcfp_pkg::*; #(
  parameter int LEVEL_STEPS = LEVEL_STEPS_DEF
) (
  input  logic [7:0] level,
  output logic [3:0] step
);

  logic [LEVEL_STEPS-2:0] hit;

  // parallel compares, then a priority pick
  always_comb begin
    for (int s = 0; s < LEVEL_STEPS - 1; s++) begin
      hit[s] = (level_at(4'(s)) >= level);
    end
  end

  always_comb begin
    step = 4'(LEVEL_STEPS - 1);
    for (int s = LEVEL_STEPS - 2; s >= 0; s--) begin
      if (hit[s]) begin
        step = 4'(s);
      end
    end
  end

endmodule

/* src/dcfp_parser.sv */
// frame state machine and display state, one transaction per take
// depends on dcfp_pkg, dcfp_digit_fix and dcfp_level_search
module dcfp_parser import dcfp_pkg::*; #(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF,
  parameter int LEVEL_STEPS = LEVEL_STEPS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    take,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  localparam int SLOT_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DIGIT_COUNT - 1);
  localparam logic [3:0] TOP_STEP = 4'(LEVEL_STEPS - 1);

  phase_t            phase, phase_next;
  logic [SLOT_W-1:0] digit_slot, digit_slot_next;
  logic [5:0]        digits [DIGIT_COUNT];
  logic [5:0]        digits_next [DIGIT_COUNT];
  logic [3:0]        brightness_step, brightness_step_next;
  logic [7:0]        brightness_value, brightness_value_next;

  logic [5:0] fixed_code;
  logic [3:0] search_step;
  logic [5:0] digit_view [4];
  logic       refresh, save_digits, soft_reset, frame_dropped;
  logic [1:0] show_request;

  dcfp_digit_fix u_fix (
    .rx_byte        (item.rx_byte),
    .old_code       (digits[digit_slot]),
    .max_digit_code (cfg.max_digit_code),
    .code           (fixed_code)
  );

  dcfp_level_search #(.LEVEL_STEPS(LEVEL_STEPS)) u_search (
    .level (item.rx_byte),
    .step  (search_step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      digit_slot       <= '0;
      brightness_step  <= STEP_RST;
      brightness_value <= LEVEL_RST;
      for (int k = 0; k < DIGIT_COUNT; k++) begin
        digits[k] <= digit_reset(k);
      end
    end else if (take) begin
      phase            <= phase_next;
      digit_slot       <= digit_slot_next;
      brightness_step  <= brightness_step_next;
      brightness_value <= brightness_value_next;
      digits           <= digits_next;
    end
  end

  always_comb begin
    phase_next            = phase;
    digit_slot_next       = digit_slot;
    digits_next           = digits;
    brightness_step_next  = brightness_step;
    brightness_value_next = brightness_value;
    refresh               = 1'b0;
    save_digits           = 1'b0;
    soft_reset            = 1'b0;
    frame_dropped         = 1'b0;
    show_request          = SHOW_NONE;

    if (item.func) begin
      // gap timeout
      if (phase != PH_IDLE) begin
        frame_dropped = 1'b1;
      end
      if (phase == PH_DIGITS) begin
        refresh = 1'b1;
      end
      phase_next      = PH_IDLE;
      digit_slot_next = '0;
    end else begin
      case (phase)
        PH_IDLE: begin
          if (item.rx_byte == ADDR_BROADCAST || item.rx_byte == cfg.board_address) begin
            phase_next = PH_CMD;
          end
        end
        PH_CMD: begin
          phase_next = PH_IDLE;
          case (item.rx_byte)
            CMD_SET_LEVEL: phase_next = PH_LEVEL;
            CMD_LEVEL_UP: begin
              if (brightness_step < TOP_STEP) begin
                brightness_step_next  = brightness_step + 4'd1;
                brightness_value_next = level_at(brightness_step + 4'd1);
              end
            end
            CMD_LEVEL_DOWN: begin
              if (brightness_step != 4'd0) begin
                brightness_step_next  = brightness_step - 4'd1;
                brightness_value_next = level_at(brightness_step - 4'd1);
              end
            end
            CMD_LOAD_DIGITS: begin
              phase_next      = PH_DIGITS;
              digit_slot_next = '0;
            end
            CMD_SAVE: save_digits = 1'b1;
            CMD_SHOW_INDIC: begin
              show_request = SHOW_INDIC;
              phase_next   = PH_SKIP;
            end
            CMD_SHOW_MODE: begin
              show_request = SHOW_MODE;
              phase_next   = PH_SKIP;
            end
            CMD_SHOW_ADDR: begin
              show_request = SHOW_ADDR;
              phase_next   = PH_SKIP;
            end
            CMD_RESET: phase_next = PH_RESET;
            default: phase_next = PH_IDLE;
          endcase
        end
        PH_LEVEL: begin
          brightness_value_next = item.rx_byte;
          brightness_step_next  = search_step;
          phase_next            = PH_IDLE;
        end
        PH_DIGITS: begin
          digits_next[digit_slot] = fixed_code;
          if (digit_slot == LAST_SLOT) begin
            refresh         = 1'b1;
            digit_slot_next = '0;
            phase_next      = PH_IDLE;
          end else begin
            digit_slot_next = digit_slot + 1'b1;
          end
        end
        PH_RESET: begin
          if (item.rx_byte == RESET_OPERAND) begin
            soft_reset            = 1'b1;
            brightness_step_next  = STEP_RST;
            brightness_value_next = LEVEL_RST;
            for (int k = 0; k < DIGIT_COUNT; k++) begin
              digits_next[k] = digit_reset(k);
            end
          end
          phase_next = PH_IDLE;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // slots beyond the configured count show their power-up code
  for (genvar k = 0; k < 4; k++) begin : g_view
    if (k < DIGIT_COUNT) begin : g_live
      assign digit_view[k] = digits_next[k];
    end else begin : g_fixed
      assign digit_view[k] = digit_reset(k);
    end
  end

  always_comb begin
    res.pwm_level     = brightness_value_next;
    res.level_step    = brightness_step_next;
    res.digit_zero    = digit_view[0];
    res.digit_one     = digit_view[1];
    res.digit_two     = digit_view[2];
    res.digit_three   = digit_view[3];
    res.refresh       = refresh;
    res.save_digits   = save_digits;
    res.soft_reset    = soft_reset;
    res.show_request  = show_request;
    res.frame_dropped = frame_dropped;
  end

endmodule

/* src/display_command_frame_parser.sv */
// top level of the display command frame parser: input register, parser,
// result register and configuration registers; depends on dcfp_pkg, dcfp_parser
//
// Takes one bus byte (or receive gap timeout) per transaction and returns one
// result transaction for each, carrying the brightness level and step, the
// four digit codes and the command pulses as they stand after that item.
// Throughput is one transaction per clock while result_stall is low: the whole
// parse step for an item is a single pass of the frame state machine between the
// input register and the result register, so the result is registered as the
// item leaves the input register. Stall on the result side holds the result
// register; the input register then absorbs one more transaction before
// item_stall rises. The configuration registers (board address, maximum direct
// digit code) are written through cfg_we/cfg_index/cfg_data and should only
// change while no transaction is in flight. There is no post-reset clearing pass.
module display_command_frame_parser import dcfp_pkg::*; #(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF,
  parameter int LEVEL_STEPS = LEVEL_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // item channel
  input  logic       item_valid,
  output logic       item_stall,
  input  item_t      item,
  // result channel
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result,
  // configuration write port
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic    s1_valid;
  item_t   s1_item;
  logic    advance;
  cfg_t    cfg;
  result_t res_next;

  // input stage moves on when the result register is empty or being drained
  assign advance    = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (item_valid && !item_stall) || (s1_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.board_address  <= BOARD_ADDRESS_RST;
      cfg.max_digit_code <= MAX_DIGIT_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOARD_ADDRESS:  cfg.board_address  <= cfg_data;
        REG_MAX_DIGIT_CODE: cfg.max_digit_code <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // frame parsing and display state
  dcfp_parser #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .LEVEL_STEPS (LEVEL_STEPS)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .take (advance),
    .item (s1_item),
    .cfg  (cfg),
    .res  (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= advance || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res_next;
    end
  end

`ifndef SYNTH
  // a soft reset result always shows the restored display
  a_soft_reset_restores: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.soft_reset |->
      result.digit_zero == 6'd1 && result.digit_one == 6'd2 &&
      result.digit_two == 6'd3 && result.digit_three == 6'd4 &&
      result.level_step == STEP_RST && result.pwm_level == LEVEL_RST)
    else $error("soft reset result without restored display");

  // a gap abort carries no command pulse
  a_drop_no_command: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frame_dropped |->
      !result.save_digits && !result.soft_reset && result.show_request == SHOW_NONE)
    else $error("frame drop together with a command pulse");

  // an empty result register never back-pressures the item side
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("item stalled while result register empty");

  // a taken item whose result is free lands in the result register next cycle
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("advanced item did not produce a result");
`endif

endmodule

/* tb/tb_display_command_frame_parser.sv */
// self-checking testbench for display_command_frame_parser: a directed table of
// frames, then random frames under several register settings with idle and stall
// bursts, each result checked against a pinned value or a parser model; uses dcfp_pkg
module tb_display_command_frame_parser;
  import dcfp_pkg::*;

  // expectation written into the table by hand, or none
  typedef struct {
    bit      used;
    result_t r;
  } typed_t;

  // one row of the directed table
  typedef struct {
    logic       func;
    logic [7:0] rx_byte;
    bit         pinned;
    result_t    want;
  } row_t;

  // brightness table, step 0 in the low byte; steps past eleven read full scale
  localparam logic [15:0][7:0] BRIGHT = {
    8'd255, 8'd255, 8'd255, 8'd255, 8'd250, 8'd214, 8'd181, 8'd146,
    8'd118, 8'd95, 8'd77, 8'd62, 8'd50, 8'd40, 8'd30, 8'd5
  };
  localparam int N_ROWS          = 35;
  localparam int RANDOM_PHASES   = 5;
  localparam int ITEMS_PER_PHASE = 220;
  localparam int CALM_TAIL       = 150;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  item_t      item = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  result_t    result;
  logic       cfg_we = 1'b0;
  logic       cfg_index = REG_BOARD_ADDRESS;
  logic [7:0] cfg_data = '0;

  // local copy of the parser state and its registers
  phase_t     ph;
  int         slot;
  logic [5:0] digit_code [DIGIT_COUNT_DEF];
  logic [3:0] bright_step;
  logic [7:0] bright_level;
  logic [7:0] own_addr;
  logic [5:0] max_code;

  typed_t     typed_results [$];
  result_t    pending_results [$];

  int n_sent = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_refresh = 0;
  int n_save = 0;
  int n_sreset = 0;
  int n_show = 0;
  int n_dropped = 0;

  // idle burst odds on each side: one chance in N per item sent, or per receiver check while not stalling; 0 for none
  int gap_odds = 0;
  int stall_odds = 0;
  int stall_left = 0;

  display_command_frame_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= 40) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want)
      flag_error($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // power-up display: digits 1..4, brightness step 10
  function automatic void restore_display();
    for (int k = 0; k < DIGIT_COUNT_DEF; k++) digit_code[k] = 6'(k + 1);
    bright_step  = STEP_RST;
    bright_level = LEVEL_RST;
  endfunction

  function automatic result_t shown(input logic [7:0] lvl, input logic [3:0] stp,
                                    input logic [5:0] d0, d1, d2, d3,
                                    input logic refresh, save, sreset);
    result_t r;
    r = '0;
    r.pwm_level   = lvl;
    r.level_step  = stp;
    r.digit_zero  = d0;
    r.digit_one   = d1;
    r.digit_two   = d2;
    r.digit_three = d3;
    r.refresh     = refresh;
    r.save_digits = save;
    r.soft_reset  = sreset;
    return r;
  endfunction

  // advances the local parser by one item and returns the display it shows
  function automatic result_t parse_item(input item_t it);
    result_t    r;
    logic [7:0] b;
    logic [5:0] code;
    logic [3:0] s;
    r = '0;
    b = it.rx_byte;
    if (it.func) begin
      // receive gap: abort any open frame, a cut digit load still refreshes
      if (ph != PH_IDLE) begin
        r.frame_dropped = 1'b1;
        r.refresh = (ph == PH_DIGITS);
      end
      ph = PH_IDLE;
      slot = 0;
    end else begin
      case (ph)
        PH_IDLE: begin
          if (b == ADDR_BROADCAST || b == own_addr) ph = PH_CMD;
        end
        PH_CMD: begin
          ph = PH_IDLE;
          case (b)
            CMD_SET_LEVEL: ph = PH_LEVEL;
            CMD_LEVEL_UP: begin
              if (bright_step < LEVEL_STEPS_DEF - 1) begin
                bright_step = bright_step + 4'd1;
                bright_level = BRIGHT[bright_step];
              end
            end
            CMD_LEVEL_DOWN: begin
              if (bright_step > 0) begin
                bright_step = bright_step - 4'd1;
                bright_level = BRIGHT[bright_step];
              end
            end
            CMD_LOAD_DIGITS: begin
              ph = PH_DIGITS;
              slot = 0;
            end
            CMD_SAVE: r.save_digits = 1'b1;
            CMD_SHOW_INDIC: begin
              r.show_request = SHOW_INDIC;
              ph = PH_SKIP;
            end
            CMD_SHOW_MODE: begin
              r.show_request = SHOW_MODE;
              ph = PH_SKIP;
            end
            CMD_SHOW_ADDR: begin
              r.show_request = SHOW_ADDR;
              ph = PH_SKIP;
            end
            CMD_RESET: ph = PH_RESET;
            default: ;  // unknown command closes the frame
          endcase
        end
        PH_LEVEL: begin
          // first table step not below the level, capped at the top step
          bright_level = b;
          s = 4'd0;
          while (s < LEVEL_STEPS_DEF - 1 && BRIGHT[s] < b) s = s + 4'd1;
          bright_step = s;
          ph = PH_IDLE;
        end
        PH_DIGITS: begin
          if (b <= {2'b00, max_code}) begin
            code = b[5:0];
          end else if (b >= CHAR_LOW && b <= CHAR_HIGH) begin
            if (b == CHAR_MINUS) code = CODE_MINUS;
            else if (b >= CHAR_ZERO && b <= CHAR_NINE) code = 6'(b - CHAR_ZERO);
            else code = CODE_OTHER;
          end else begin
            code = digit_code[slot];
          end
          digit_code[slot] = code;
          slot++;
          if (slot >= DIGIT_COUNT_DEF) begin
            r.refresh = 1'b1;
            slot = 0;
            ph = PH_IDLE;
          end
        end
        PH_RESET: begin
          if (b == RESET_OPERAND) begin
            r.soft_reset = 1'b1;
            restore_display();
          end
          ph = PH_IDLE;
        end
        default: ph = PH_IDLE;  // show operand is skipped
      endcase
    end
    r.pwm_level   = bright_level;
    r.level_step  = bright_step;
    r.digit_zero  = digit_code[0];
    r.digit_one   = digit_code[1];
    r.digit_two   = digit_code[2];
    r.digit_three = digit_code[3];
    return r;
  endfunction

  // receiver side: random stall bursts on the result channel
  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
      stall_left = $urandom_range(1, 10);
    result_stall <= (stall_left > 0);
  end

  // predict on every accepted item transaction, check every accepted result
  always @(posedge clk) begin
    typed_t  t;
    result_t guess;
    result_t want;
    if (!rst) begin
      if (item_valid === 1'b1 && item_stall === 1'b0) begin
        guess = parse_item(item);
        t.used = 1'b0;
        t.r = '0;
        if (typed_results.size() != 0) t = typed_results.pop_front();
        pending_results.push_back(t.used ? t.r : guess);
      end
      if (result_valid === 1'b1 && result_stall === 1'b0) begin
        n_results++;
        if (pending_results.size() == 0) begin
          flag_error("result transaction with nothing expected");
        end else begin
          want = pending_results.pop_front();
          compare_field("pwm_level", result.pwm_level, want.pwm_level);
          compare_field("level_step", 8'(result.level_step), 8'(want.level_step));
          compare_field("digit_zero", 8'(result.digit_zero), 8'(want.digit_zero));
          compare_field("digit_one", 8'(result.digit_one), 8'(want.digit_one));
          compare_field("digit_two", 8'(result.digit_two), 8'(want.digit_two));
          compare_field("digit_three", 8'(result.digit_three), 8'(want.digit_three));
          compare_field("refresh", 8'(result.refresh), 8'(want.refresh));
          compare_field("save_digits", 8'(result.save_digits), 8'(want.save_digits));
          compare_field("soft_reset", 8'(result.soft_reset), 8'(want.soft_reset));
          compare_field("show_request", 8'(result.show_request),
                        8'(want.show_request));
          compare_field("frame_dropped", 8'(result.frame_dropped),
                        8'(want.frame_dropped));
          n_refresh += int'(want.refresh);
          n_save    += int'(want.save_digits);
          n_sreset  += int'(want.soft_reset);
          n_show    += int'(want.show_request != SHOW_NONE);
          n_dropped += int'(want.frame_dropped);
        end
      end
    end
  end

  // one item transaction, with an optional idle burst in front of it
  task automatic send(input item_t it, input bit pinned, input result_t want);
    typed_t t;
    int     n;
    t.used = pinned;
    t.r = want;
    typed_results.push_back(t);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      item_valid <= 1'b0;
      n = $urandom_range(1, 10);
      repeat (n) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall !== 1'b0);
    n_sent++;
  endtask

  // wait until every result is back, then let the pipeline run dry
  task automatic settle();
    item_valid <= 1'b0;
    while (n_results != n_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // a mostly well-formed frame with random content, sometimes cut by a gap
  task automatic send_frame(output int count);
    item_t      seq [$];
    item_t      it;
    logic [7:0] cmd;
    int         cut;
    it.func = 1'b0;
    case ($urandom_range(0, 9))
      0:       it.rx_byte = 8'($urandom);  // stray address, usually ignored
      1, 2, 3: it.rx_byte = ADDR_BROADCAST;
      default: it.rx_byte = own_addr;
    endcase
    seq.push_back(it);
    case ($urandom_range(0, 10))
      0:       cmd = CMD_SET_LEVEL;
      1:       cmd = CMD_LEVEL_DOWN;
      2:       cmd = CMD_LEVEL_UP;
      3, 4:    cmd = CMD_LOAD_DIGITS;
      5:       cmd = CMD_SAVE;
      6:       cmd = CMD_SHOW_INDIC;
      7:       cmd = CMD_SHOW_MODE;
      8:       cmd = CMD_SHOW_ADDR;
      9:       cmd = CMD_RESET;
      default: cmd = 8'($urandom);
    endcase
    it.rx_byte = cmd;
    seq.push_back(it);
    if (cmd == CMD_SET_LEVEL) begin
      // table values and their neighbors hit the step search boundaries
      case ($urandom_range(0, 3))
        0: it.rx_byte = BRIGHT[$urandom_range(0, 11)] + 8'($urandom_range(0, 2)) - 8'd1;
        1: it.rx_byte = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: it.rx_byte = 8'($urandom);
      endcase
      seq.push_back(it);
    end else if (cmd == CMD_LOAD_DIGITS) begin
      for (int k = 0; k < DIGIT_COUNT_DEF; k++) begin
        case ($urandom_range(0, 4))
          0:       it.rx_byte = 8'($urandom_range(0, max_code));
          1:       it.rx_byte = 8'($urandom_range(CHAR_LOW, CHAR_HIGH));
          2:       it.rx_byte = {2'b00, max_code} + 8'd1;
          3:       it.rx_byte = 8'($urandom_range(0, 63));
          default: it.rx_byte = 8'($urandom);
        endcase
        seq.push_back(it);
      end
    end else if (cmd == CMD_RESET) begin
      it.rx_byte = $urandom_range(0, 1) ? RESET_OPERAND : 8'($urandom);
      seq.push_back(it);
    end else if (cmd == CMD_SHOW_INDIC || cmd == CMD_SHOW_MODE || cmd == CMD_SHOW_ADDR) begin
      it.rx_byte = 8'($urandom);
      seq.push_back(it);
    end
    // one frame in ten is cut short by a receive gap
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, seq.size());
      while (seq.size() > cut) void'(seq.pop_back());
      it.func = 1'b1;
      it.rx_byte = 8'($urandom);
      seq.push_back(it);
    end
    count = seq.size();
    foreach (seq[i]) send(seq[i], 1'b0, '0);
  endtask

  initial begin
    row_t       script [N_ROWS];
    result_t    home;
    item_t      it;
    logic [7:0] addr;
    logic [5:0] maxc;
    int         r;
    int         p;
    int         left;
    int         seg;
    int         got;

    // model starts from the block's reset state
    restore_display();
    ph = PH_IDLE;
    slot = 0;
    own_addr = BOARD_ADDRESS_RST;
    max_code = MAX_DIGIT_CODE_RST;

    home = shown(LEVEL_RST, STEP_RST, 6'd1, 6'd2, 6'd3, 6'd4, 1'b0, 1'b0, 1'b0);
    // directed frames at the reset register values; unpinned rows use the model
    script = '{
      '{1'b1, 8'h00, 1'b1, home},                    // gap while idle
      '{1'b0, 8'h00, 1'b1, home},                    // foreign address dropped
      '{1'b0, ADDR_BROADCAST, 1'b0, '0},
      '{1'b0, CMD_SET_LEVEL, 1'b0, '0},
      '{1'b0, 8'h00, 1'b1, shown(8'd0, 4'd0, 6'd1, 6'd2, 6'd3, 6'd4,
                                 1'b0, 1'b0, 1'b0)},
      '{1'b0, BOARD_ADDRESS_RST, 1'b0, '0},          // own address
      '{1'b0, CMD_LEVEL_DOWN, 1'b1, shown(8'd0, 4'd0, 6'd1, 6'd2, 6'd3, 6'd4,
                                          1'b0, 1'b0, 1'b0)},
      '{1'b0, ADDR_BROADCAST, 1'b0, '0},
      '{1'b0, CMD_SET_LEVEL, 1'b0, '0},
      '{1'b0, 8'hFF, 1'b1, shown(8'd255, 4'd11, 6'd1, 6'd2, 6'd3, 6'd4,
                                 1'b0, 1'b0, 1'b0)},
      '{1'b0, ADDR_BROADCAST, 1'b0, '0},
      '{1'b0, CMD_LOAD_DIGITS, 1'b0, '0},
      '{1'b0, 8'h0C, 1'b0, '0},                      // equal to max code, kept
      '{1'b0, CHAR_MINUS, 1'b0, '0},
      '{1'b0, CHAR_HIGH, 1'b0, '0},
      '{1'b0, 8'hFF, 1'b1, shown(8'd255, 4'd11, 6'd12, 6'd10, 6'd11, 6'd4,
                                 1'b1, 1'b0, 1'b0)},
      '{1'b0, ADDR_BROADCAST, 1'b0, '0},
      '{1'b0, CMD_SAVE, 1'b1, shown(8'd255, 4'd11, 6'd12, 6'd10, 6'd11, 6'd4,
                                    1'b0, 1'b1, 1'b0)},
      '{1'b0, ADDR_BROADCAST, 1'b0, '0},
      '{1'b0, CMD_SHOW_INDIC, 1'b0, '0},
      '{1'b0, 8'h00, 1'b0, '0},
      '{1'b0, ADDR_BROADCAST, 1'b0, '0},
      '{1'b0, CMD_SHOW_MODE, 1'b0, '0},
      '{1'b1, 8'hA5, 1'b0, '0},                      // gap while skipping operand
      '{1'b0, ADDR_BROADCAST, 1'b0, '0},
      '{1'b0, CMD_SHOW_ADDR, 1'b0, '0},
      '{1'b0, 8'h7F, 1'b0, '0},
      '{1'b0, ADDR_BROADCAST, 1'b0, '0},
      '{1'b0, CMD_RESET, 1'b0, '0},
      '{1'b0, RESET_OPERAND, 1'b1, shown(LEVEL_RST, STEP_RST, 6'd1, 6'd2, 6'd3, 6'd4,
                                         1'b0, 1'b0, 1'b1)},
      '{1'b0, ADDR_BROADCAST, 1'b0, '0},
      '{1'b0, CMD_LOAD_DIGITS, 1'b0, '0},
      '{1'b0, 8'h35, 1'b0, '0},
      '{1'b1, 8'h5A, 1'b0, '0},                      // gap cuts the digit load
      '{1'b0, 8'h57, 1'b0, '0}                       // stray byte in idle
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    gap_odds = 4;
    stall_odds = 4;
    for (r = 0; r < N_ROWS; r++) begin
      it.func = script[r].func;
      it.rx_byte = script[r].rx_byte;
      send(it, script[r].pinned, script[r].want);
    end
    // broadcast plus unknown command once the parser is back in idle
    it.func = 1'b0;
    it.rx_byte = ADDR_BROADCAST;
    send(it, 1'b0, '0);
    it.rx_byte = 8'h57;
    send(it, 1'b0, '0);
    settle();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      // register extremes first, then random settings
      case (p)
        0: begin
          addr = 8'd0;
          maxc = 6'd0;
        end
        1: begin
          addr = 8'd254;
          maxc = 6'd41;
        end
        2: begin
          addr = ADDR_BROADCAST;  // own address equal to broadcast
          maxc = MAX_DIGIT_CODE_RST;
        end
        default: begin
          addr = 8'($urandom_range(0, 254));
          maxc = 6'($urandom_range(0, 41));
        end
      endcase
      cfg_we <= 1'b1;
      cfg_index <= REG_BOARD_ADDRESS;
      cfg_data <= addr;
      @(posedge clk);
      cfg_index <= REG_MAX_DIGIT_CODE;
      cfg_data <= {2'b00, maxc};
      @(posedge clk);
      cfg_we <= 1'b0;
      own_addr = addr;
      max_code = maxc;

      left = ITEMS_PER_PHASE;
      seg = 0;
      while (left > 0) begin
        if (p == RANDOM_PHASES - 1 && left < CALM_TAIL) begin
          // final stretch runs at full rate on both sides
          gap_odds = 0;
          stall_odds = 0;
        end else if (seg <= 0) begin
          case ($urandom_range(0, 2))
            0:       gap_odds = 0;
            1:       gap_odds = 3;
            default: gap_odds = 8;
          endcase
          case ($urandom_range(0, 2))
            0:       stall_odds = 0;
            1:       stall_odds = 3;
            default: stall_odds = 8;
          endcase
          seg = 60;
        end
        // stray byte or gap between frames
        if ($urandom_range(0, 5) == 0) begin
          it.func = 1'($urandom_range(0, 1));
          it.rx_byte = 8'($urandom);
          send(it, 1'b0, '0);
        end
        send_frame(got);
        left -= got;
        seg -= got;
      end
      settle();
    end

    if (pending_results.size() != 0) flag_error("expected results left over at end of run");
    $display("checked %0d result transactions over %0d register settings", n_results,
             RANDOM_PHASES + 1);
    $display("seen: %0d refresh, %0d save, %0d soft reset, %0d show, %0d dropped frames",
             n_refresh, n_save, n_sreset, n_show, n_dropped);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/dcfp_pkg.sv
src/dcfp_digit_fix.sv
src/dcfp_level_search.sv
src/dcfp_parser.sv
src/display_command_frame_parser.sv
tb/tb_display_command_frame_parser.sv
